// File: rtl/i2c_master_transaction_sequencer_macros.svh
// Assertion macros used by the checker file.
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_MACROS_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_MACROS_SVH

// same-cycle implication
`define I2CM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2cm check failed");

// next-cycle implication
`define I2CM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2cm check failed");

`endif

// File: rtl/i2cm_pkg.sv
package i2cm_pkg;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_SEND,
    CMD_READ_ACK,
    CMD_READ_NACK,
    CMD_STOP
  } cmd_t;

  typedef enum logic [2:0] {
    RC_OK,
    RC_START_FAIL,
    RC_SLAW_NACK,
    RC_DATA_NACK,
    RC_RSTART_FAIL,
    RC_SLAR_NACK
  } rc_t;

  typedef enum logic [1:0] {
    MODE_WRITE,
    MODE_READ,
    MODE_WRITE_READ,
    MODE_SCAN
  } mode_t;

  typedef enum logic [2:0] {
    CFG_MODE,
    CFG_TARGET_ADDRESS,
    CFG_WRITE_COUNT,
    CFG_READ_COUNT,
    CFG_SCAN_LIMIT
  } cfg_idx_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START_W,
    PH_START_R,
    PH_SLA_W,
    PH_DATA_W,
    PH_RSTART,
    PH_SLA_R,
    PH_DATA_R,
    PH_SCAN_START,
    PH_SCAN_SLA
  } phase_t;

  localparam logic [7:0] ST_START    = 8'h08;
  localparam logic [7:0] ST_RSTART   = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK = 8'h18;
  localparam logic [7:0] ST_DATA_ACK = 8'h28;
  localparam logic [7:0] ST_SLAR_ACK = 8'h40;
  localparam logic [6:0] ADDR_LAST   = 7'd127;

  typedef struct packed {
    mode_t      mode;
    logic [6:0] target_address;
    logic [7:0] write_count;
    logic [7:0] read_count;
    logic [6:0] scan_limit;
  } cfg_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] bytes_done;
    logic       read_half;
    logic [6:0] scan_address;
    logic [6:0] found_total;
  } seq_state_t;

  typedef struct packed {
    logic       func;
    logic [7:0] bus_status;
    logic [7:0] bus_byte;
    logic [7:0] write_data;
  } in_word_t;

  typedef struct packed {
    cmd_t       bus_command;
    logic [7:0] send_byte;
    logic       read_valid;
    logic [7:0] received_byte;
    logic       found_valid;
    logic [6:0] found_address;
    logic       done_res;
    rc_t        result_code;
    logic [7:0] failing_status;
    logic [6:0] found_count;
    logic       last;
  } res_t;

endpackage

// File: rtl/i2cm_step.sv
module i2cm_step (
  input  i2cm_pkg::cfg_t       cfg,
  input  i2cm_pkg::seq_state_t st,
  input  i2cm_pkg::in_word_t   in_word,
  output i2cm_pkg::seq_state_t st_nxt,
  output logic [1:0]           res_cnt,
  output i2cm_pkg::res_t       res0,
  output i2cm_pkg::res_t       res1
);
  import i2cm_pkg::*;

  logic       fail;
  rc_t        fail_code;
  logic [7:0] reads_wanted;
  logic [8:0] rd_done;
  logic [7:0] wr_done;
  logic [6:0] ft_inc;
  logic [6:0] ft_next;
  logic       hit;
  logic       scan_end;

  assign reads_wanted = (cfg.read_count == 8'd0) ? 8'd1 : cfg.read_count;
  assign rd_done      = {1'b0, st.bytes_done} + 9'd1;
  assign wr_done      = (st.phase == PH_SLA_W) ? 8'd0 : st.bytes_done;
  assign ft_inc       = st.found_total + 7'd1;
  assign hit          = (in_word.bus_status == ST_SLAW_ACK);
  assign ft_next      = hit ? ft_inc : st.found_total;
  assign scan_end     = (hit && (ft_next == cfg.scan_limit)) || (st.scan_address >= ADDR_LAST);

  always_comb begin
    st_nxt    = st;
    res_cnt   = 2'd0;
    res0      = '0;
    res1      = '0;
    res0.last = 1'b1;
    res1.last = 1'b1;
    fail      = 1'b0;
    fail_code = RC_OK;
    if (!in_word.func) begin
      if (st.phase == PH_IDLE) begin
        res_cnt          = 2'd1;
        res0.bus_command = CMD_START;
        st_nxt.bytes_done = 8'd0;
        st_nxt.read_half  = (cfg.mode == MODE_WRITE_READ);
        unique case (cfg.mode)
          MODE_SCAN: begin
            st_nxt.scan_address = 7'd1;
            st_nxt.found_total  = 7'd0;
            st_nxt.phase        = PH_SCAN_START;
          end
          MODE_READ:       st_nxt.phase = PH_START_R;
          MODE_WRITE,
          MODE_WRITE_READ: st_nxt.phase = PH_START_W;
          default:         st_nxt.phase = PH_START_W;
        endcase
      end
    end else begin
      unique case (st.phase)
        PH_START_W, PH_START_R: begin
          if (in_word.bus_status != ST_START) begin
            fail      = 1'b1;
            fail_code = RC_START_FAIL;
          end else begin
            res_cnt          = 2'd1;
            res0.bus_command = CMD_SEND;
            if (st.phase == PH_START_R) begin
              res0.send_byte = {cfg.target_address, 1'b1};
              st_nxt.phase   = PH_SLA_R;
            end else begin
              res0.send_byte = {cfg.target_address, 1'b0};
              st_nxt.phase   = PH_SLA_W;
            end
          end
        end
        PH_SLA_W, PH_DATA_W: begin
          if (st.phase == PH_SLA_W && in_word.bus_status != ST_SLAW_ACK) begin
            fail      = 1'b1;
            fail_code = RC_SLAW_NACK;
          end else if (st.phase == PH_DATA_W && in_word.bus_status != ST_DATA_ACK) begin
            fail      = 1'b1;
            fail_code = RC_DATA_NACK;
          end else begin
            res_cnt = 2'd1;
            if (wr_done >= cfg.write_count) begin
              st_nxt.bytes_done = wr_done;
              if (st.read_half) begin
                res0.bus_command = CMD_START;
                st_nxt.phase     = PH_RSTART;
              end else begin
                res0.bus_command = CMD_STOP;
                res0.done_res    = 1'b1;
                st_nxt.phase     = PH_IDLE;
              end
            end else begin
              st_nxt.bytes_done = wr_done + 8'd1;
              res0.bus_command  = CMD_SEND;
              res0.send_byte    = in_word.write_data;
              st_nxt.phase      = PH_DATA_W;
            end
          end
        end
        PH_RSTART: begin
          if (in_word.bus_status != ST_RSTART) begin
            fail      = 1'b1;
            fail_code = RC_RSTART_FAIL;
          end else begin
            res_cnt          = 2'd1;
            res0.bus_command = CMD_SEND;
            res0.send_byte   = {cfg.target_address, 1'b1};
            st_nxt.phase     = PH_SLA_R;
          end
        end
        PH_SLA_R: begin
          if (in_word.bus_status != ST_SLAR_ACK) begin
            fail      = 1'b1;
            fail_code = RC_SLAR_NACK;
          end else begin
            res_cnt           = 2'd1;
            st_nxt.bytes_done = 8'd0;
            res0.bus_command  = (reads_wanted == 8'd1) ? CMD_READ_NACK : CMD_READ_ACK;
            st_nxt.phase      = PH_DATA_R;
          end
        end
        PH_DATA_R: begin
          res_cnt            = 2'd1;
          st_nxt.bytes_done  = rd_done[7:0];
          res0.read_valid    = 1'b1;
          res0.received_byte = in_word.bus_byte;
          if (rd_done >= {1'b0, reads_wanted}) begin
            res0.bus_command = CMD_STOP;
            res0.done_res    = 1'b1;
            st_nxt.phase     = PH_IDLE;
          end else if ((rd_done + 9'd1) == {1'b0, reads_wanted}) begin
            res0.bus_command = CMD_READ_NACK;
          end else begin
            res0.bus_command = CMD_READ_ACK;
          end
        end
        PH_SCAN_START: begin
          res_cnt          = 2'd1;
          res0.bus_command = CMD_SEND;
          res0.send_byte   = {st.scan_address, 1'b0};
          st_nxt.phase     = PH_SCAN_SLA;
        end
        PH_SCAN_SLA: begin
          res0.bus_command   = CMD_STOP;
          res0.found_valid   = hit;
          res0.found_address = hit ? st.scan_address : 7'd0;
          st_nxt.found_total = ft_next;
          if (scan_end) begin
            res_cnt          = 2'd1;
            res0.done_res    = 1'b1;
            res0.found_count = ft_next;
            st_nxt.phase     = PH_IDLE;
          end else begin
            res_cnt              = 2'd2;
            res0.last            = 1'b0;
            res1.bus_command     = CMD_START;
            st_nxt.scan_address  = st.scan_address + 7'd1;
            st_nxt.phase         = PH_SCAN_START;
          end
        end
        PH_IDLE: res_cnt = 2'd0;
        default: st_nxt.phase = PH_IDLE;
      endcase
      if (fail) begin
        res0                = '0;
        res0.bus_command    = CMD_STOP;
        res0.done_res       = 1'b1;
        res0.result_code    = fail_code;
        res0.failing_status = in_word.bus_status;
        res0.last           = 1'b1;
        res_cnt             = 2'd1;
        st_nxt.phase        = PH_IDLE;
      end
    end
  end

endmodule

// File: rtl/i2cm_oq.sv
module i2cm_oq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [1:0]     push_cnt,
  input  i2cm_pkg::res_t d0,
  input  i2cm_pkg::res_t d1,
  input  logic           pop,
  output i2cm_pkg::res_t q,
  output logic           q_valid,
  output logic           room
);
  import i2cm_pkg::*;

  res_t       slot_r [4];
  logic [1:0] wp_r;
  logic [1:0] rp_r;
  logic [2:0] cnt_r;
  logic [1:0] wp_nxt;
  logic [1:0] rp_nxt;
  logic [2:0] cnt_nxt;
  logic [1:0] wp_inc;

  assign wp_inc  = wp_r + 2'd1;
  assign q       = slot_r[rp_r];
  assign q_valid = (cnt_r != 3'd0);
  assign room    = (cnt_r <= 3'd2);

  always_comb begin
    wp_nxt  = wp_r + push_cnt;
    rp_nxt  = rp_r + {1'b0, pop};
    cnt_nxt = cnt_r + {1'b0, push_cnt} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      slot_r[wp_r] <= d0;
    end
    if (push_cnt == 2'd2) begin
      slot_r[wp_inc] <= d1;
    end
  end

endmodule

// File: rtl/i2c_master_transaction_sequencer.sv
// Channel   Dir  Handshake           Word
// in_       in   in_valid/in_ready   func, bus_status, bus_byte, write_data
// out_      out  out_valid/out_ready one bus step with its status fields
// cfg_      in   cfg_we              cfg_index selects, cfg_wdata carries
//
// One input word per cycle while the queue has room; its one or two result
// words enter a four-word output queue in the same edge and leave at one per
// cycle while out_ready is high. A scan step that goes on yields two words,
// so the single output port of the queue limits the input rate of a scan.
// in_ready drops while fewer than two queue slots are free.
// Active-low sync reset presets state and config, clears queue pointers.
module i2c_master_transaction_sequencer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_func,
  input  logic [7:0] in_bus_status,
  input  logic [7:0] in_bus_byte,
  input  logic [7:0] in_write_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_bus_command,
  output logic [7:0] out_send_byte,
  output logic       out_read_valid,
  output logic [7:0] out_received_byte,
  output logic       out_found_valid,
  output logic [6:0] out_found_address,
  output logic       out_done_res,
  output logic [2:0] out_result_code,
  output logic [7:0] out_failing_status,
  output logic [6:0] out_found_count,
  output logic       out_last,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_wdata
);
  import i2cm_pkg::*;

  cfg_t       cfg_r;
  seq_state_t st_r;
  seq_state_t st_nxt;
  in_word_t   in_word;
  logic [1:0] res_cnt;
  res_t       res0;
  res_t       res1;
  res_t       head;
  logic       accept;
  logic       room;

  assign in_word = '{func: in_func, bus_status: in_bus_status,
                     bus_byte: in_bus_byte, write_data: in_write_data};
  assign in_ready = room;
  assign accept   = in_valid && room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode           <= MODE_WRITE;
      cfg_r.target_address <= 7'd0;
      cfg_r.write_count    <= 8'd0;
      cfg_r.read_count     <= 8'd1;
      cfg_r.scan_limit     <= 7'd127;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MODE:           cfg_r.mode           <= mode_t'(cfg_wdata[1:0]);
        CFG_TARGET_ADDRESS: cfg_r.target_address <= cfg_wdata[6:0];
        CFG_WRITE_COUNT:    cfg_r.write_count    <= cfg_wdata;
        CFG_READ_COUNT:     cfg_r.read_count     <= cfg_wdata;
        CFG_SCAN_LIMIT:     cfg_r.scan_limit     <= cfg_wdata[6:0];
        default:            cfg_r                <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase        <= PH_IDLE;
      st_r.bytes_done   <= 8'd0;
      st_r.read_half    <= 1'b0;
      st_r.scan_address <= 7'd1;
      st_r.found_total  <= 7'd0;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

  i2cm_step u_step (
    .cfg     (cfg_r),
    .st      (st_r),
    .in_word (in_word),
    .st_nxt  (st_nxt),
    .res_cnt (res_cnt),
    .res0    (res0),
    .res1    (res1)
  );

  i2cm_oq u_oq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (accept ? res_cnt : 2'd0),
    .d0       (res0),
    .d1       (res1),
    .pop      (out_valid && out_ready),
    .q        (head),
    .q_valid  (out_valid),
    .room     (room)
  );

  assign out_bus_command    = head.bus_command;
  assign out_send_byte      = head.send_byte;
  assign out_read_valid     = head.read_valid;
  assign out_received_byte  = head.received_byte;
  assign out_found_valid    = head.found_valid;
  assign out_found_address  = head.found_address;
  assign out_done_res       = head.done_res;
  assign out_result_code    = head.result_code;
  assign out_failing_status = head.failing_status;
  assign out_found_count    = head.found_count;
  assign out_last           = head.last;

endmodule

// File: rtl/i2cm_check.sv
`include "i2c_master_transaction_sequencer_macros.svh"

module i2cm_check (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_bus_command,
  input logic       out_done_res,
  input logic [2:0] out_result_code,
  input logic [7:0] out_failing_status,
  input logic       out_last
);
  import i2cm_pkg::*;

  `I2CM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `I2CM_ASSERT_NOW(a_done_is_stop, out_valid && out_done_res, out_bus_command == CMD_STOP && out_last)
  `I2CM_ASSERT_NOW(a_ok_no_status, out_valid && out_done_res && out_result_code == RC_OK, out_failing_status == 8'd0)
  `I2CM_ASSERT_NOW(a_code_needs_done, out_valid && !out_done_res, out_result_code == RC_OK)
  `I2CM_ASSERT_NEXT(a_pair_then_start, out_valid && out_ready && !out_last, out_valid && out_bus_command == CMD_START && out_last)

endmodule

bind i2c_master_transaction_sequencer i2cm_check u_i2cm_check (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_bus_command    (out_bus_command),
  .out_done_res       (out_done_res),
  .out_result_code    (out_result_code),
  .out_failing_status (out_failing_status),
  .out_last           (out_last)
);

// File: dv/i2c_master_transaction_sequencer_test.sv
`timescale 1ns / 1ps

module i2c_master_transaction_sequencer_test;
  import i2cm_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 60;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_func = 1'b0;
  logic [7:0] in_bus_status = 8'd0;
  logic [7:0] in_bus_byte = 8'd0;
  logic [7:0] in_write_data = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_bus_command;
  logic [7:0] out_send_byte;
  logic       out_read_valid;
  logic [7:0] out_received_byte;
  logic       out_found_valid;
  logic [6:0] out_found_address;
  logic       out_done_res;
  logic [2:0] out_result_code;
  logic [7:0] out_failing_status;
  logic [6:0] out_found_count;
  logic       out_last;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = 3'd0;
  logic [7:0] cfg_wdata = 8'd0;

  i2c_master_transaction_sequencer u_top (.*);

  // sequencer state and register copies
  phase_t     seq_phase;
  logic [7:0] seq_count;
  logic       seq_read_half;
  logic [6:0] seq_probe;
  logic [6:0] seq_found;
  mode_t      reg_mode;
  logic [6:0] reg_target;
  logic [7:0] reg_wcount;
  logic [7:0] reg_rcount;
  logic [6:0] reg_limit;

  in_word_t bus_events[$];
  res_t     due_steps[$];
  in_word_t offer;
  in_word_t seen_word;
  res_t     exp_step;

  logic in_fire = 1'b0;
  logic drained = 1'b1;
  int   errors = 0;
  int   cycles = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_asks = 0;
  int   hold_done = 0;
  int   hold_left = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic abort_transfer(input rc_t code, input logic [7:0] status);
    res_t r;
    r = '0;
    r.bus_command = CMD_STOP;
    r.done_res = 1'b1;
    r.result_code = code;
    r.failing_status = status;
    r.last = 1'b1;
    due_steps.push_back(r);
    seq_phase = PH_IDLE;
  endtask

  task automatic advance_sequencer(input in_word_t w);
    res_t       r;
    logic [7:0] want;
    logic [8:0] got_n;
    logic       hit;
    r = '0;
    r.last = 1'b1;
    want = (reg_rcount == 8'd0) ? 8'd1 : reg_rcount;
    if (w.func == 1'b0) begin
      if (seq_phase == PH_IDLE) begin
        seq_count = 8'd0;
        seq_read_half = (reg_mode == MODE_WRITE_READ);
        if (reg_mode == MODE_SCAN) begin
          seq_probe = 7'd1;
          seq_found = 7'd0;
          seq_phase = PH_SCAN_START;
        end else if (reg_mode == MODE_READ) begin
          seq_phase = PH_START_R;
        end else begin
          seq_phase = PH_START_W;
        end
        r.bus_command = CMD_START;
        due_steps.push_back(r);
      end
    end else begin
      case (seq_phase)
        PH_START_W, PH_START_R: begin
          if (w.bus_status != ST_START) begin
            abort_transfer(RC_START_FAIL, w.bus_status);
          end else begin
            r.bus_command = CMD_SEND;
            if (seq_phase == PH_START_R) begin
              r.send_byte = {reg_target, 1'b1};
              seq_phase = PH_SLA_R;
            end else begin
              r.send_byte = {reg_target, 1'b0};
              seq_phase = PH_SLA_W;
            end
            due_steps.push_back(r);
          end
        end
        PH_SLA_W, PH_DATA_W: begin
          if (seq_phase == PH_SLA_W && w.bus_status != ST_SLAW_ACK) begin
            abort_transfer(RC_SLAW_NACK, w.bus_status);
          end else if (seq_phase == PH_DATA_W && w.bus_status != ST_DATA_ACK) begin
            abort_transfer(RC_DATA_NACK, w.bus_status);
          end else begin
            if (seq_phase == PH_SLA_W) seq_count = 8'd0;
            if (seq_count >= reg_wcount) begin
              if (seq_read_half) begin
                r.bus_command = CMD_START;
                seq_phase = PH_RSTART;
              end else begin
                r.bus_command = CMD_STOP;
                r.done_res = 1'b1;
                seq_phase = PH_IDLE;
              end
            end else begin
              seq_count = seq_count + 8'd1;
              r.bus_command = CMD_SEND;
              r.send_byte = w.write_data;
              seq_phase = PH_DATA_W;
            end
            due_steps.push_back(r);
          end
        end
        PH_RSTART: begin
          if (w.bus_status != ST_RSTART) begin
            abort_transfer(RC_RSTART_FAIL, w.bus_status);
          end else begin
            r.bus_command = CMD_SEND;
            r.send_byte = {reg_target, 1'b1};
            seq_phase = PH_SLA_R;
            due_steps.push_back(r);
          end
        end
        PH_SLA_R: begin
          if (w.bus_status != ST_SLAR_ACK) begin
            abort_transfer(RC_SLAR_NACK, w.bus_status);
          end else begin
            seq_count = 8'd0;
            if (want == 8'd1) r.bus_command = CMD_READ_NACK;
            else r.bus_command = CMD_READ_ACK;
            seq_phase = PH_DATA_R;
            due_steps.push_back(r);
          end
        end
        PH_DATA_R: begin
          got_n = seq_count + 9'd1;
          seq_count = got_n[7:0];
          r.read_valid = 1'b1;
          r.received_byte = w.bus_byte;
          if (got_n >= want) begin
            r.bus_command = CMD_STOP;
            r.done_res = 1'b1;
            seq_phase = PH_IDLE;
          end else if (got_n + 9'd1 == want) begin
            r.bus_command = CMD_READ_NACK;
          end else begin
            r.bus_command = CMD_READ_ACK;
          end
          due_steps.push_back(r);
        end
        PH_SCAN_START: begin
          r.bus_command = CMD_SEND;
          r.send_byte = {seq_probe, 1'b0};
          seq_phase = PH_SCAN_SLA;
          due_steps.push_back(r);
        end
        PH_SCAN_SLA: begin
          hit = (w.bus_status == ST_SLAW_ACK);
          r.bus_command = CMD_STOP;
          if (hit) begin
            seq_found = seq_found + 7'd1;
            r.found_valid = 1'b1;
            r.found_address = seq_probe;
          end
          if ((hit && seq_found == reg_limit) || seq_probe >= ADDR_LAST) begin
            r.done_res = 1'b1;
            r.found_count = seq_found;
            seq_phase = PH_IDLE;
            due_steps.push_back(r);
          end else begin
            r.last = 1'b0;
            due_steps.push_back(r);
            seq_probe = seq_probe + 7'd1;
            r = '0;
            r.bus_command = CMD_START;
            r.last = 1'b1;
            due_steps.push_back(r);
            seq_phase = PH_SCAN_START;
          end
        end
        default: seq_phase = PH_IDLE;
      endcase
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // input side: offer the next word once the current one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (bus_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        offer = bus_events.pop_front();
        in_valid <= 1'b1;
        in_func <= offer.func;
        in_bus_status <= offer.bus_status;
        in_bus_byte <= offer.bus_byte;
        in_write_data <= offer.write_data;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side: random stalls, long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asks != hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= hold_done + 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_fire <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      seen_word = {in_func, in_bus_status, in_bus_byte, in_write_data};
      advance_sequencer(seen_word);
    end
    if (rst_n && out_valid && out_ready) begin
      if (due_steps.size() == 0) begin
        $error("bus step with nothing due: command %0d", out_bus_command);
        errors++;
      end else begin
        exp_step = due_steps.pop_front();
        check_field("bus_command", 8'(exp_step.bus_command), 8'(out_bus_command));
        check_field("send_byte", exp_step.send_byte, out_send_byte);
        check_field("read_valid", 8'(exp_step.read_valid), 8'(out_read_valid));
        check_field("received_byte", exp_step.received_byte, out_received_byte);
        check_field("found_valid", 8'(exp_step.found_valid), 8'(out_found_valid));
        check_field("found_address", 8'(exp_step.found_address), 8'(out_found_address));
        check_field("done_res", 8'(exp_step.done_res), 8'(out_done_res));
        check_field("result_code", 8'(exp_step.result_code), 8'(out_result_code));
        check_field("failing_status", exp_step.failing_status, out_failing_status);
        check_field("found_count", 8'(exp_step.found_count), 8'(out_found_count));
        check_field("last", 8'(exp_step.last), 8'(out_last));
      end
    end
    drained <= (due_steps.size() == 0);
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_full(input logic f, input logic [7:0] st, input logic [7:0] rx,
                           input logic [7:0] wd);
    in_word_t w;
    w.func = f;
    w.bus_status = st;
    w.bus_byte = rx;
    w.write_data = wd;
    bus_events.push_back(w);
  endtask

  task automatic push_word(input logic f, input logic [7:0] st);
    push_full(f, st, 8'($urandom), 8'($urandom));
  endtask

  function automatic logic [7:0] other_than(input logic [7:0] v);
    logic [7:0] x;
    x = 8'($urandom);
    while (x == v) x = 8'($urandom);
    return x;
  endfunction

  task automatic apply_config(input mode_t md, input logic [6:0] ta, input logic [7:0] wc,
                              input logic [7:0] rc, input logic [6:0] lim);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MODE;
    cfg_wdata <= {6'd0, md};
    @(negedge clk);
    cfg_index <= CFG_TARGET_ADDRESS;
    cfg_wdata <= {1'b0, ta};
    @(negedge clk);
    cfg_index <= CFG_WRITE_COUNT;
    cfg_wdata <= wc;
    @(negedge clk);
    cfg_index <= CFG_READ_COUNT;
    cfg_wdata <= rc;
    @(negedge clk);
    cfg_index <= CFG_SCAN_LIMIT;
    cfg_wdata <= {1'b0, lim};
    @(negedge clk);
    cfg_we <= 1'b0;
    reg_mode = md;
    reg_target = ta;
    reg_wcount = wc;
    reg_rcount = rc;
    reg_limit = lim;
    @(posedge clk);
  endtask

  // hold the sender until the block has answered everything
  task automatic settle();
    while (bus_events.size() != 0 || in_valid || !drained) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // one transaction in the current mode; a non-scan one may be broken at a checked step
  task automatic gen_transfer(input int fail_pct, input int hit_pct, inout int made);
    logic [7:0] steps[$];
    int         nchecked;
    int         nreads;
    int         cut;
    int         busy_at;
    int         found;
    int         addr;
    logic       hit;
    logic       scanning;
    nchecked = 0;
    if (reg_mode == MODE_SCAN) begin
      found = 0;
      addr = 1;
      scanning = 1'b1;
      while (scanning) begin
        steps.push_back(8'($urandom));
        hit = ($urandom_range(0, 99) < hit_pct);
        if (hit) begin
          steps.push_back(ST_SLAW_ACK);
          found++;
        end else begin
          steps.push_back(other_than(ST_SLAW_ACK));
        end
        if ((hit && found == reg_limit) || addr >= ADDR_LAST) scanning = 1'b0;
        else addr++;
      end
    end else begin
      steps.push_back(ST_START);
      if (reg_mode == MODE_READ) begin
        steps.push_back(ST_SLAR_ACK);
      end else begin
        steps.push_back(ST_SLAW_ACK);
        repeat (reg_wcount) steps.push_back(ST_DATA_ACK);
        if (reg_mode == MODE_WRITE_READ) begin
          steps.push_back(ST_RSTART);
          steps.push_back(ST_SLAR_ACK);
        end
      end
      nchecked = steps.size();
      if (reg_mode != MODE_WRITE) begin
        nreads = (reg_rcount == 8'd0) ? 1 : reg_rcount;
        repeat (nreads) steps.push_back(8'($urandom));
      end
      if ($urandom_range(0, 99) < fail_pct) begin
        cut = $urandom_range(0, nchecked - 1);
        steps[cut] = other_than(steps[cut]);
        while (steps.size() > cut + 1) void'(steps.pop_back());
      end
    end
    if ($urandom_range(0, 9) == 0) push_word(1'b1, 8'($urandom));
    busy_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, steps.size() - 1) : -1;
    push_word(1'b0, 8'($urandom));
    made++;
    foreach (steps[i]) begin
      if (i == busy_at) push_word(1'b0, 8'($urandom));
      push_word(1'b1, steps[i]);
      made++;
    end
  endtask

  initial begin : stimulus
    int         p;
    int         base;
    int         made;
    int         guard;
    mode_t      md;
    logic [6:0] ta;
    logic [6:0] lim;
    logic [7:0] wc;
    logic [7:0] rc;

    seq_phase = PH_IDLE;
    seq_count = 8'd0;
    seq_read_half = 1'b0;
    seq_probe = 7'd1;
    seq_found = 7'd0;
    reg_mode = MODE_WRITE;
    reg_target = 7'd0;
    reg_wcount = 8'd0;
    reg_rcount = 8'd1;
    reg_limit = 7'd127;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 36;
    recv_idle_pct = 50;

    // reset settings: stray completion, then a bare address write
    push_full(1'b1, 8'hFF, 8'hFF, 8'hFF);
    push_full(1'b0, 8'h00, 8'h00, 8'h00);
    push_word(1'b1, ST_START);
    push_word(1'b1, ST_SLAW_ACK);
    settle();

    // write then repeated-start read, zero read count, begin while busy
    apply_config(MODE_WRITE_READ, 7'd127, 8'd1, 8'd0, 7'd127);
    push_word(1'b0, 8'h00);
    push_word(1'b0, 8'hFF);
    push_word(1'b1, ST_START);
    push_full(1'b1, ST_SLAW_ACK, 8'h00, 8'hFF);
    push_full(1'b1, ST_DATA_ACK, 8'h00, 8'h00);
    push_word(1'b1, ST_RSTART);
    push_word(1'b1, ST_SLAR_ACK);
    push_full(1'b1, 8'hFF, 8'hFF, 8'h00);
    settle();

    apply_config(MODE_READ, 7'h55, 8'd0, 8'd2, 7'd1);
    push_word(1'b0, 8'hFF);
    push_full(1'b1, 8'h00, 8'h00, 8'hFF);
    settle();

    // scan start status is don't-care; first hit meets the limit
    apply_config(MODE_SCAN, 7'h2A, 8'd255, 8'd255, 7'd1);
    push_word(1'b0, 8'h00);
    push_full(1'b1, 8'hFF, 8'h00, 8'h00);
    push_word(1'b1, ST_SLAW_ACK);
    settle();

    apply_config(MODE_WRITE, 7'd0, 8'd1, 8'd1, 7'd1);
    push_word(1'b0, 8'h00);
    push_word(1'b1, ST_START);
    push_word(1'b1, ST_SLAW_ACK);
    push_full(1'b1, 8'h20, 8'hFF, 8'hFF);
    settle();

    base = $urandom_range(0, 3);
    for (p = 0; p < 12; p++) begin
      send_idle_pct = (p < 4) ? 36 : (p < 8) ? 50 : 0;
      recv_idle_pct = (p < 4) ? 50 : (p < 8) ? 36 : 0;
      md = mode_t'((p + base) % 4);
      case ($urandom_range(0, 3))
        0: ta = 7'd0;
        1: ta = 7'd127;
        default: ta = 7'($urandom);
      endcase
      wc = 8'($urandom_range(0, 5));
      rc = 8'($urandom_range(0, 5));
      if (md == MODE_SCAN) lim = 7'($urandom_range(1, 6));
      else lim = $urandom_range(0, 1) ? 7'd127 : 7'($urandom_range(1, 127));
      if (p == 2) begin
        md = MODE_WRITE_READ;
        wc = 8'd150;
        rc = 8'd30;
      end
      if (p == 6) begin
        md = MODE_SCAN;
        lim = 7'd0;
      end
      apply_config(md, ta, wc, rc, lim);
      made = 0;
      if (p == 2 || p == 6) gen_transfer(0, 50, made);
      else while (made < 5) gen_transfer(25, 60, made);
      if (p == 1 || p == 9) hold_asks++;
      settle();
    end

    guard = 0;
    while ((bus_events.size() != 0 || in_valid || !drained) && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    @(negedge clk);
    if (due_steps.size() != 0) begin
      $error("%0d bus steps never arrived", due_steps.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/i2cm_pkg.sv
rtl/i2cm_step.sv
rtl/i2cm_oq.sv
rtl/i2c_master_transaction_sequencer.sv
rtl/i2cm_check.sv
dv/i2c_master_transaction_sequencer_test.sv
